// ===== hw/rtl/gbnsw_pkg.sv =====
// ----------------------------------------------------------------------------
// gbnsw_pkg
// Types and constants shared by the go-back-N sender window unit.
// ----------------------------------------------------------------------------
package gbnsw_pkg;

   localparam int PAYLOAD_BYTES = 1024;
   localparam int MAX_PACKETS   = 1024;
   localparam int WINDOW_MAX    = 32;
   localparam int WINDOW_CAP    = (WINDOW_MAX < 32) ? WINDOW_MAX : 32;

   localparam logic [5:0] WINDOW_RESET = 6'd8;

   localparam logic [1:0] REQ_START   = 2'd0;
   localparam logic [1:0] REQ_ACK     = 2'd1;
   localparam logic [1:0] REQ_TIMEOUT = 2'd2;

   typedef enum logic [2:0] {
      STATUS_ADVANCED  = 3'd0,
      STATUS_BAD_SUM   = 3'd1,
      STATUS_STALE     = 3'd2,
      STATUS_START_OK  = 3'd3,
      STATUS_START_REJ = 3'd4,
      STATUS_RESEND    = 3'd5,
      STATUS_IGNORED   = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      MODE_NONE   = 2'd0,
      MODE_FILL   = 2'd1,
      MODE_RESEND = 2'd2
   } mode_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] seq_origin;
      logic [20:0] message_length;
      logic [15:0] ack_seq;
      logic        ack_checksum_ok;
   } req_item_type;

   typedef struct packed {
      logic        send_valid;
      logic [15:0] send_seq;
      logic [9:0]  packet_index;
      logic        is_resend;
      logic [2:0]  event_status;
      logic        transfer_done;
      logic        last;
   } rsp_item_type;

   typedef struct packed {
      logic load_event;
      logic step;
   } dp_cmd_type;

   typedef struct packed {
      logic cand_last;
   } dp_status_type;

endpackage

// ===== hw/rtl/gbnsw_ctrl.sv =====
// ----------------------------------------------------------------------------
// gbnsw_ctrl
// Controller: accepts one transaction, then steps the datapath once per
// result until the final one is loaded into the output register.
// ----------------------------------------------------------------------------
module gbnsw_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output gbnsw_pkg::dp_cmd_type    dp_cmd,
   input  gbnsw_pkg::dp_status_type dp_status
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign dp_cmd.load_event = req_valid && req_ready;
   assign dp_cmd.step       = (state_ff == ST_EMIT) && slot_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free && dp_status.cand_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (dp_cmd.step) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hw/rtl/gbnsw_dpath.sv =====
// ----------------------------------------------------------------------------
// gbnsw_dpath
// Datapath: window state, event decode, send cursor and output register.
// ----------------------------------------------------------------------------
module gbnsw_dpath (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [5:0]               csr_wr_data,
   input  gbnsw_pkg::req_item_type  req_data,
   output gbnsw_pkg::rsp_item_type  rsp_data,
   input  gbnsw_pkg::dp_cmd_type    dp_cmd,
   output gbnsw_pkg::dp_status_type dp_status
);

   logic [5:0]  win_limit_ff;
   logic [15:0] base_ff, next_ff, end_ff, first_ff, cursor_ff;
   logic        active_ff, done_ff;
   gbnsw_pkg::mode_type     mode_ff;
   gbnsw_pkg::status_type   status_ff;
   gbnsw_pkg::rsp_item_type rsp_data_ff;

   logic [5:0]  w_eff;
   logic [15:0] outstanding, outstanding_inc, next_inc, cursor_inc, send_seq;
   logic        fill_send, fill_more, resend_send, resend_more;
   logic        have_send, have_more;
   logic [21:0] len_round, pkt_count;
   logic        start_ok;
   logic [15:0] ack_dist;

   always_comb begin
      if (win_limit_ff == 6'd0) w_eff = 6'd1;
      else if (win_limit_ff > 6'(gbnsw_pkg::WINDOW_CAP)) w_eff = 6'(gbnsw_pkg::WINDOW_CAP);
      else w_eff = win_limit_ff;
   end

   assign outstanding     = next_ff - base_ff;
   assign outstanding_inc = outstanding + 16'd1;
   assign next_inc        = next_ff + 16'd1;
   assign cursor_inc      = cursor_ff + 16'd1;

   assign fill_send   = (mode_ff == gbnsw_pkg::MODE_FILL) && active_ff &&
                        (outstanding < 16'(w_eff)) && (next_ff != end_ff);
   assign fill_more   = (outstanding_inc < 16'(w_eff)) && (next_inc != end_ff);
   assign resend_send = (mode_ff == gbnsw_pkg::MODE_RESEND) && (cursor_ff != next_ff);
   assign resend_more = (cursor_inc != next_ff);

   assign have_send = fill_send || resend_send;
   assign have_more = fill_send ? fill_more : resend_more;
   assign send_seq  = fill_send ? next_ff : cursor_ff;

   assign dp_status.cand_last = !have_send || !have_more;

   assign len_round = 22'(req_data.message_length) + 22'(gbnsw_pkg::PAYLOAD_BYTES - 1);
   assign pkt_count = len_round / 22'(gbnsw_pkg::PAYLOAD_BYTES);
   assign start_ok  = !active_ff && (pkt_count <= 22'(gbnsw_pkg::MAX_PACKETS)) &&
                      (pkt_count <= 22'd65535);
   assign ack_dist  = req_data.ack_seq - base_ff;

   assign rsp_data = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_limit_ff <= gbnsw_pkg::WINDOW_RESET;
         base_ff      <= '0;
         next_ff      <= '0;
         end_ff       <= '0;
         first_ff     <= '0;
         active_ff    <= 1'b0;
         mode_ff      <= gbnsw_pkg::MODE_NONE;
      end else begin
         if (csr_wr_en) win_limit_ff <= csr_wr_data;
         if (dp_cmd.load_event) begin
            mode_ff <= gbnsw_pkg::MODE_NONE;
            case (req_data.req_type)
               gbnsw_pkg::REQ_START: begin
                  if (start_ok) begin
                     first_ff  <= req_data.seq_origin;
                     base_ff   <= req_data.seq_origin;
                     next_ff   <= req_data.seq_origin;
                     end_ff    <= req_data.seq_origin + pkt_count[15:0];
                     active_ff <= (pkt_count != 22'd0);
                     if (pkt_count != 22'd0) mode_ff <= gbnsw_pkg::MODE_FILL;
                  end
               end
               gbnsw_pkg::REQ_ACK: begin
                  if (active_ff) begin
                     mode_ff <= gbnsw_pkg::MODE_FILL;
                     if (req_data.ack_checksum_ok && (ack_dist <= outstanding)) begin
                        base_ff <= req_data.ack_seq;
                        if (req_data.ack_seq == end_ff) active_ff <= 1'b0;
                     end
                  end
               end
               gbnsw_pkg::REQ_TIMEOUT: begin
                  if (active_ff) mode_ff <= gbnsw_pkg::MODE_RESEND;
               end
               default: mode_ff <= gbnsw_pkg::MODE_NONE;
            endcase
         end else if (dp_cmd.step && fill_send) begin
            next_ff <= next_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load_event) begin
         cursor_ff <= base_ff;
         done_ff   <= 1'b0;
         status_ff <= gbnsw_pkg::STATUS_IGNORED;
         case (req_data.req_type)
            gbnsw_pkg::REQ_START: begin
               if (start_ok) begin
                  status_ff <= gbnsw_pkg::STATUS_START_OK;
                  done_ff   <= (pkt_count == 22'd0);
               end else begin
                  status_ff <= gbnsw_pkg::STATUS_START_REJ;
               end
            end
            gbnsw_pkg::REQ_ACK: begin
               if (active_ff) begin
                  if (!req_data.ack_checksum_ok) begin
                     status_ff <= gbnsw_pkg::STATUS_BAD_SUM;
                  end else if (ack_dist > outstanding) begin
                     status_ff <= gbnsw_pkg::STATUS_STALE;
                  end else begin
                     status_ff <= gbnsw_pkg::STATUS_ADVANCED;
                     done_ff   <= (req_data.ack_seq == end_ff);
                  end
               end
            end
            gbnsw_pkg::REQ_TIMEOUT: begin
               if (active_ff) status_ff <= gbnsw_pkg::STATUS_RESEND;
            end
            default: status_ff <= gbnsw_pkg::STATUS_IGNORED;
         endcase
      end else if (dp_cmd.step) begin
         if (resend_send) cursor_ff <= cursor_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.step) begin
         rsp_data_ff.send_valid    <= have_send;
         rsp_data_ff.send_seq      <= have_send ? send_seq : 16'd0;
         rsp_data_ff.packet_index  <= have_send ? 10'(send_seq - first_ff) : 10'd0;
         rsp_data_ff.is_resend     <= resend_send;
         rsp_data_ff.event_status  <= status_ff;
         rsp_data_ff.transfer_done <= done_ff;
         rsp_data_ff.last          <= dp_status.cand_last;
      end
   end

endmodule

// ===== hw/rtl/go_back_n_sender_window_unit.sv =====
// ----------------------------------------------------------------------------
// go_back_n_sender_window_unit
// Go-back-N sender window control: start, cumulative ACK and timeout events
// produce the sequence numbers to send or resend.
// ----------------------------------------------------------------------------
//  channel  ports            direction  meaning
//  req      req_valid/ready  in         one event transaction
//  rsp      rsp_valid/ready  out        one send (or status-only) result
//  csr      csr_wr_en/data   in         window size register
//
//  One event is accepted, then produces 1 to 32 results, the result count
//  set by the window; the send cursor steps once per cycle while rsp is not stalled.
//  Synchronous active-high reset; window size resets to 8.
//  A stalled rsp holds the cursor; the next event is taken once the last
//  result of the current one sits in the output register.
// ----------------------------------------------------------------------------
module go_back_n_sender_window_unit (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  gbnsw_pkg::req_item_type req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output gbnsw_pkg::rsp_item_type rsp_data,
   input  logic                    csr_wr_en,
   input  logic [5:0]              csr_wr_data
);

   gbnsw_pkg::dp_cmd_type    dp_cmd;
   gbnsw_pkg::dp_status_type dp_status;

   gbnsw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   gbnsw_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_data    (req_data),
      .rsp_data    (rsp_data),
      .dp_cmd      (dp_cmd),
      .dp_status   (dp_status)
   );

endmodule

// ===== hw/rtl/gbnsw_checker.sv =====
// ----------------------------------------------------------------------------
// gbnsw_checker
// Port-level checks for the go-back-N sender window unit.
// ----------------------------------------------------------------------------
module gbnsw_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input gbnsw_pkg::rsp_item_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp transaction changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req accepted while previous transaction in progress");

   a_nosend_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.send_valid |-> rsp_data.last &&
      rsp_data.send_seq == 16'd0 && rsp_data.packet_index == 10'd0 &&
      !rsp_data.is_resend)
      else $error("status-only result malformed");

   a_resend_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_resend |->
      rsp_data.event_status == gbnsw_pkg::STATUS_RESEND && rsp_data.send_valid)
      else $error("resend without resend status");

endmodule

bind go_back_n_sender_window_unit gbnsw_checker u_gbnsw_checker (.*);

// ===== sim/tb_go_back_n_sender_window_unit.sv =====
// ----------------------------------------------------------------------------
// tb_go_back_n_sender_window_unit
// Self-checking bench for the go-back-N sender window unit. Directed events
// cover idle, start, ACK and timeout corners. Random event streams follow,
// mostly well-formed transfers with ACKs and timeouts. The window register
// runs through 8, 0, 63, 1 and 32. A scoreboard class predicts every result
// and compares each field in order.
// ----------------------------------------------------------------------------
module tb_go_back_n_sender_window_unit;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          RESET_CYCLES = 12;
   localparam int          STALL_LIMIT  = 4000;
   localparam int          HOLD_CYCLES  = 300;
   localparam int          DRAIN_CYCLES = 40;
   localparam int          RESULT_CAP   = 32;
   localparam logic [1:0]  REQ_UNUSED   = 2'd3;
   localparam logic [20:0] LENGTH_MAX   = 21'h1FFFFF;

   class window_scoreboard;
      logic [5:0]              win_limit;
      logic [15:0]             base_seq;
      logic [15:0]             next_seq;
      logic [15:0]             end_seq;
      logic [15:0]             first_seq;
      bit                      active;
      gbnsw_pkg::rsp_item_type awaited_results[$];
      gbnsw_pkg::rsp_item_type event_results[$];
      int                      event_count;
      int                      result_count;
      int                      error_count;

      function new();
         win_limit    = gbnsw_pkg::WINDOW_RESET;
         base_seq     = '0;
         next_seq     = '0;
         end_seq      = '0;
         first_seq    = '0;
         active       = 1'b0;
         event_count  = 0;
         result_count = 0;
         error_count  = 0;
      endfunction

      function void add_send(logic [15:0] seq, logic resend);
         gbnsw_pkg::rsp_item_type item;
         logic [15:0]             offset;
         offset            = seq - first_seq;
         item              = '0;
         item.send_valid   = 1'b1;
         item.send_seq     = seq;
         item.packet_index = offset[9:0];
         item.is_resend    = resend;
         event_results.push_back(item);
      endfunction

      function void fill_window();
         int unsigned window;
         logic [15:0] in_flight;
         window = 32'(win_limit);
         if (window == 0) window = 1;
         if (window > gbnsw_pkg::WINDOW_CAP) window = gbnsw_pkg::WINDOW_CAP;
         in_flight = next_seq - base_seq;
         while (active && 32'(in_flight) < window && next_seq != end_seq &&
                event_results.size() < RESULT_CAP) begin
            add_send(next_seq, 1'b0);
            next_seq  = next_seq + 16'd1;
            in_flight = next_seq - base_seq;
         end
      endfunction

      // Predict all results of one accepted transaction.
      function void apply_event(gbnsw_pkg::req_item_type ev);
         gbnsw_pkg::status_type status;
         logic                  done;
         int unsigned           packets;
         logic [15:0]           ack_gap;
         logic [15:0]           sent_gap;
         logic [15:0]           cursor;
         status = gbnsw_pkg::STATUS_IGNORED;
         done   = 1'b0;
         event_results.delete();
         event_count++;
         if (ev.req_type == gbnsw_pkg::REQ_START) begin
            packets = (int'(ev.message_length) + gbnsw_pkg::PAYLOAD_BYTES - 1) /
                      gbnsw_pkg::PAYLOAD_BYTES;
            if (active || packets > gbnsw_pkg::MAX_PACKETS || packets > 65535) begin
               status = gbnsw_pkg::STATUS_START_REJ;
            end else begin
               status    = gbnsw_pkg::STATUS_START_OK;
               first_seq = ev.seq_origin;
               base_seq  = ev.seq_origin;
               next_seq  = ev.seq_origin;
               end_seq   = ev.seq_origin + packets[15:0];
               if (packets == 0) begin
                  done   = 1'b1;
                  active = 1'b0;
               end else begin
                  active = 1'b1;
                  fill_window();
               end
            end
         end else if (ev.req_type == gbnsw_pkg::REQ_ACK && active) begin
            ack_gap  = ev.ack_seq - base_seq;
            sent_gap = next_seq - base_seq;
            if (!ev.ack_checksum_ok) begin
               status = gbnsw_pkg::STATUS_BAD_SUM;
            end else if (ack_gap > sent_gap) begin
               status = gbnsw_pkg::STATUS_STALE;
            end else begin
               status   = gbnsw_pkg::STATUS_ADVANCED;
               base_seq = ev.ack_seq;
               if (base_seq == end_seq) begin
                  done   = 1'b1;
                  active = 1'b0;
               end
            end
            fill_window();
         end else if (ev.req_type == gbnsw_pkg::REQ_TIMEOUT && active) begin
            status = gbnsw_pkg::STATUS_RESEND;
            cursor = base_seq;
            while (cursor != next_seq && event_results.size() < RESULT_CAP) begin
               add_send(cursor, 1'b1);
               cursor = cursor + 16'd1;
            end
         end
         if (event_results.size() == 0) event_results.push_back('0);
         foreach (event_results[k]) begin
            event_results[k].event_status  = status;
            event_results[k].transfer_done = done;
            event_results[k].last          = (k == event_results.size() - 1);
            awaited_results.push_back(event_results[k]);
         end
      endfunction

      function void compare(string field, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            error_count++;
         end
      endfunction

      function void check_result(gbnsw_pkg::rsp_item_type got);
         gbnsw_pkg::rsp_item_type want;
         if (awaited_results.size() == 0) begin
            $display("%0t: result with none expected, actual %p", $time, got);
            error_count++;
            return;
         end
         want = awaited_results.pop_front();
         result_count++;
         compare("send_valid", 16'(want.send_valid), 16'(got.send_valid));
         compare("send_seq", want.send_seq, got.send_seq);
         compare("packet_index", 16'(want.packet_index), 16'(got.packet_index));
         compare("is_resend", 16'(want.is_resend), 16'(got.is_resend));
         compare("event_status", 16'(want.event_status), 16'(got.event_status));
         compare("transfer_done", 16'(want.transfer_done), 16'(got.transfer_done));
         compare("last", 16'(want.last), 16'(got.last));
      endfunction
   endclass

   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    req_valid   = 1'b0;
   logic                    req_ready;
   gbnsw_pkg::req_item_type req_data    = '0;
   logic                    rsp_valid;
   logic                    rsp_ready   = 1'b0;
   gbnsw_pkg::rsp_item_type rsp_data;
   logic                    csr_wr_en   = 1'b0;
   logic [5:0]              csr_wr_data = '0;

   window_scoreboard sb;
   int unsigned      sender_idle_pct   = 33;
   int unsigned      receiver_idle_pct = 82;
   bit               hold_request      = 1'b0;
   int               hold_left         = 0;
   int               stall_cycles      = 0;

   go_back_n_sender_window_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   // Receiver: random back-pressure, plus one long hold when requested.
   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_data);
   end

   initial begin : watchdog
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles = 0;
         else stall_cycles++;
      end
      $display("go_back_n_sender_window_unit verification failed");
      $finish;
   end

   function automatic gbnsw_pkg::req_item_type make_event(logic [1:0] kind,
                                                          logic [15:0] first,
                                                          logic [20:0] length,
                                                          logic [15:0] ack,
                                                          logic ack_ok);
      gbnsw_pkg::req_item_type ev;
      ev.req_type        = kind;
      ev.seq_origin      = first;
      ev.message_length  = length;
      ev.ack_seq         = ack;
      ev.ack_checksum_ok = ack_ok;
      return ev;
   endfunction

   // Mostly well-formed traffic for the current state, with some noise.
   function automatic gbnsw_pkg::req_item_type random_event();
      gbnsw_pkg::req_item_type ev;
      int unsigned             pick;
      logic [15:0]             sent_gap;
      ev = make_event(2'($urandom_range(3)), 16'($urandom_range(16'hFFFF)),
                      21'($urandom_range(LENGTH_MAX)), 16'($urandom_range(16'hFFFF)),
                      1'($urandom_range(1)));
      pick     = $urandom_range(99);
      sent_gap = sb.next_seq - sb.base_seq;
      if (!sb.active) begin
         if (pick < 70) begin
            ev.req_type       = gbnsw_pkg::REQ_START;
            ev.message_length = 21'((pick < 10) ? $urandom_range(1024) :
                                    (pick < 55) ? $urandom_range(12 * 1024, 1) :
                                    $urandom_range(48 * 1024, 12 * 1024 + 1));
            if ($urandom_range(3) == 0) begin
               ev.seq_origin = 16'($urandom_range(16'hFFFF, 16'hFFE0));
            end
         end else if (pick < 78) begin
            ev.req_type       = gbnsw_pkg::REQ_START;
            ev.message_length = 21'($urandom_range(LENGTH_MAX, 21'h100001));
         end else if (pick < 86) begin
            ev.req_type = gbnsw_pkg::REQ_ACK;
         end else if (pick < 94) begin
            ev.req_type = gbnsw_pkg::REQ_TIMEOUT;
         end else begin
            ev.req_type = REQ_UNUSED;
         end
      end else begin
         if (pick < 50) begin
            ev.req_type        = gbnsw_pkg::REQ_ACK;
            ev.ack_checksum_ok = 1'b1;
            ev.ack_seq         = sb.base_seq +
                                 16'(($urandom_range(2) == 0) ? 32'(sent_gap) :
                                     $urandom_range(sent_gap));
         end else if (pick < 60) begin
            ev.req_type        = gbnsw_pkg::REQ_ACK;
            ev.ack_checksum_ok = 1'b0;
         end else if (pick < 70) begin
            ev.req_type        = gbnsw_pkg::REQ_ACK;
            ev.ack_checksum_ok = 1'b1;
            ev.ack_seq         = sb.base_seq + 16'($urandom_range(16'hFFFF, sent_gap + 1));
         end else if (pick < 85) begin
            ev.req_type = gbnsw_pkg::REQ_TIMEOUT;
         end else if (pick < 93) begin
            ev.req_type = gbnsw_pkg::REQ_START;
         end else begin
            ev.req_type = REQ_UNUSED;
         end
      end
      return ev;
   endfunction

   task automatic offer_event(gbnsw_pkg::req_item_type ev);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= ev;
      do @(posedge clock); while (!req_ready);
      sb.apply_event(ev);
   endtask

   task automatic offer_random(int count);
      repeat (count) offer_event(random_event());
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (sb.awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_window(logic [5:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.win_limit = value;
   endtask

   task automatic ack_to(logic [15:0] ack, logic ack_ok);
      offer_event(make_event(gbnsw_pkg::REQ_ACK, 16'($urandom_range(16'hFFFF)),
                             21'($urandom_range(LENGTH_MAX)), ack, ack_ok));
   endtask

   task automatic raise(logic [1:0] kind);
      offer_event(make_event(kind, 16'($urandom_range(16'hFFFF)),
                             21'($urandom_range(LENGTH_MAX)),
                             16'($urandom_range(16'hFFFF)), 1'($urandom_range(1))));
   endtask

   task automatic start_transfer(logic [15:0] first, logic [20:0] length);
      offer_event(make_event(gbnsw_pkg::REQ_START, first, length,
                             16'($urandom_range(16'hFFFF)), 1'($urandom_range(1))));
   endtask

   initial begin : stimulus
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: idle events, rejected starts, a wrapping transfer of ten packets
      ack_to(16'hFFFF, 1'b1);
      raise(gbnsw_pkg::REQ_TIMEOUT);
      offer_event(make_event(REQ_UNUSED, 16'hFFFF, LENGTH_MAX, 16'hFFFF, 1'b1));
      offer_event(make_event(gbnsw_pkg::REQ_START, 16'h0000, LENGTH_MAX, 16'h0000, 1'b0));
      start_transfer(16'h0000, 21'h100001);
      start_transfer(16'h1234, 21'd0);
      start_transfer(16'hFFFC, 21'd10240);
      start_transfer(16'h0100, 21'd1);
      ack_to(16'h8000, 1'b0);
      ack_to(16'hFFFB, 1'b1);
      ack_to(16'h0005, 1'b1);
      raise(gbnsw_pkg::REQ_TIMEOUT);
      ack_to(16'hFFFC, 1'b1);
      ack_to(16'h0000, 1'b1);
      raise(gbnsw_pkg::REQ_TIMEOUT);
      ack_to(16'h0006, 1'b1);
      raise(gbnsw_pkg::REQ_TIMEOUT);
      start_transfer(16'h0000, 21'd1);
      ack_to(16'h0001, 1'b1);
      start_transfer(16'h0000, 21'd1025);
      ack_to(16'h0002, 1'b1);

      settle();
      write_window(6'd0);
      offer_random(25);

      settle();
      sender_idle_pct   = 82;
      receiver_idle_pct = 33;
      write_window(6'd63);
      offer_random(25);

      settle();
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      write_window(6'd1);
      hold_request = 1'b1;
      offer_random(20);

      settle();
      write_window(6'd32);
      while (sb.active) ack_to(sb.next_seq, 1'b1);
      start_transfer(16'($urandom_range(16'hFFFF)), 21'h100000);
      offer_random(20);

      settle();
      $display("Covered %0d transactions and %0d results under windows 8, 0, 63, 1, 32,",
               sb.event_count, sb.result_count);
      $display("with sender-heavy, receiver-heavy and no idling and one long receiver hold.");
      if (sb.error_count == 0) begin
         $display("go_back_n_sender_window_unit verification clean");
      end else begin
         $display("go_back_n_sender_window_unit verification failed");
      end
      $finish;
   end

endmodule
